// File: sv/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Types, codes and helper functions for the string escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int CP_W    = 21;
  localparam int ACC_W   = 32;
  localparam int MAX_RES = 5;
  localparam int CNT_W   = 3;

  typedef enum logic [2:0] {
    ST_BYTE           = 3'd0,
    ST_END_IN_ESCAPE  = 3'd1,
    ST_BAD_DIGIT      = 3'd2,
    ST_BAD_CODE_POINT = 3'd3,
    ST_COMPLETE       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_AFTER_BSLASH,
    MODE_DIGITS
  } mode_t;

  typedef enum logic [1:0] {
    KIND_HEX_BYTE,
    KIND_UNICODE,
    KIND_OCTAL
  } kind_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       run_end;
  } out_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } utf8_t;

  // characters of the literal text
  localparam logic [CP_W-1:0] CH_BSLASH = 21'h5C;
  localparam logic [CP_W-1:0] CH_SQUOTE = 21'h27;
  localparam logic [CP_W-1:0] CH_DQUOTE = 21'h22;
  localparam logic [CP_W-1:0] CH_UNDER  = 21'h5F;
  localparam logic [CP_W-1:0] CH_LO_A   = 21'h61;
  localparam logic [CP_W-1:0] CH_LO_B   = 21'h62;
  localparam logic [CP_W-1:0] CH_LO_E   = 21'h65;
  localparam logic [CP_W-1:0] CH_LO_F   = 21'h66;
  localparam logic [CP_W-1:0] CH_LO_N   = 21'h6E;
  localparam logic [CP_W-1:0] CH_LO_R   = 21'h72;
  localparam logic [CP_W-1:0] CH_LO_T   = 21'h74;
  localparam logic [CP_W-1:0] CH_LO_U   = 21'h75;
  localparam logic [CP_W-1:0] CH_LO_V   = 21'h76;
  localparam logic [CP_W-1:0] CH_LO_X   = 21'h78;
  localparam logic [CP_W-1:0] CH_UP_A   = 21'h41;
  localparam logic [CP_W-1:0] CH_UP_F   = 21'h46;
  localparam logic [CP_W-1:0] CH_UP_U   = 21'h55;
  localparam logic [CP_W-1:0] CH_ZERO   = 21'h30;
  localparam logic [CP_W-1:0] CH_SEVEN  = 21'h37;
  localparam logic [CP_W-1:0] CH_NINE   = 21'h39;

  // control bytes
  localparam logic [7:0] BYTE_BEL = 8'h07;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_VT  = 8'h0B;

  localparam logic [ACC_W-1:0] CP_MAX     = 32'h0010_FFFF;
  localparam logic [ACC_W-1:0] SURR_FIRST = 32'h0000_D800;
  localparam logic [ACC_W-1:0] SURR_LAST  = 32'h0000_DFFF;

  // utf-8 layout, first byte in bytes[0]
  function automatic utf8_t utf8_encode(logic [CP_W-1:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.bytes[0] = cp[7:0];
      r.len      = 3'd1;
    end else if (cp < 21'h800) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.len      = 3'd2;
    end else if (cp < 21'h10000) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.len      = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.len      = 3'd4;
    end
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] digit_value(logic [CP_W-1:0] cp, kind_t kind);
    logic [4:0] r;
    r = '0;
    if (kind == KIND_OCTAL) begin
      if (cp >= CH_ZERO && cp <= CH_SEVEN) r = {1'b1, 4'(cp - CH_ZERO)};
    end else if (cp >= CH_ZERO && cp <= CH_NINE) begin
      r = {1'b1, 4'(cp - CH_ZERO)};
    end else if (cp >= CH_LO_A && cp <= CH_LO_F) begin
      r = {1'b1, 4'(cp - CH_LO_A + 21'd10)};
    end else if (cp >= CH_UP_A && cp <= CH_UP_F) begin
      r = {1'b1, 4'(cp - CH_UP_A + 21'd10)};
    end
    return r;
  endfunction

endpackage

// File: sv/string_escape_decoder_core.sv
// ----------------------------------------------------------------------------
// string_escape_decoder_core
// Decodes a string literal, one code point per request, into UTF-8 bytes.
// ----------------------------------------------------------------------------
// One request is decoded in the cycle it is accepted and its results (up to
// five: four UTF-8 bytes and a completion status) are loaded into a result
// register that shifts out one result per cycle while out_stall is low. The
// next request is accepted in the cycle the last result of the one before
// leaves, so results flow with no gap. Requests that yield no result
// (backslash, escape digits) are taken one per cycle while the result
// register is empty. The single-result output register sets the rate of the
// stream.
module string_escape_decoder_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sed_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sed_pkg::out_t  out_data
);

  sed_pkg::mode_t                  mode_r, mode_nxt;
  sed_pkg::kind_t                  kind_r, kind_nxt;
  logic [3:0]                      dl_r, dl_nxt;
  logic [sed_pkg::ACC_W-1:0]       acc_r, acc_nxt;
  logic                            err_r, err_nxt;

  sed_pkg::out_t                   q_r [sed_pkg::MAX_RES];
  sed_pkg::out_t                   q_nxt [sed_pkg::MAX_RES];
  logic [sed_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;

  sed_pkg::out_t                   list [sed_pkg::MAX_RES];
  logic [sed_pkg::CNT_W-1:0]       n;

  logic                            in_fire;
  logic                            pop;
  logic [sed_pkg::CP_W-1:0]        cp;
  logic                            last;
  logic                            do_enc, do_byte, do_flag, do_eie;
  logic [sed_pkg::CP_W-1:0]        enc_src;
  logic [7:0]                      byte_val;
  sed_pkg::status_t                flag_stat;
  sed_pkg::utf8_t                  enc;
  logic [4:0]                      dv;
  logic [sed_pkg::ACC_W-1:0]       acc_new;
  logic [3:0]                      dl_dec;

  assign in_stall  = (cnt_r > 3'd1) || ((cnt_r == 3'd1) && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign pop       = (cnt_r != '0) && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[0];
  assign cp        = in_data.code_point;
  assign last      = in_data.end_of_text;

  // decode
  always_comb begin
    mode_nxt  = mode_r;
    kind_nxt  = kind_r;
    dl_nxt    = dl_r;
    acc_nxt   = acc_r;
    err_nxt   = err_r;
    do_enc    = 1'b0;
    do_byte   = 1'b0;
    do_flag   = 1'b0;
    do_eie    = 1'b0;
    enc_src   = cp;
    byte_val  = '0;
    flag_stat = sed_pkg::ST_BAD_DIGIT;
    dv        = '0;
    acc_new   = acc_r;
    dl_dec    = dl_r;

    if (in_fire && !err_r) begin
      unique case (mode_r)
        sed_pkg::MODE_PLAIN: begin
          if (cp == sed_pkg::CH_BSLASH) begin
            mode_nxt = sed_pkg::MODE_AFTER_BSLASH;
          end else begin
            do_enc  = 1'b1;
            enc_src = cp;
          end
        end
        sed_pkg::MODE_AFTER_BSLASH: begin
          mode_nxt = sed_pkg::MODE_PLAIN;
          priority if (cp == sed_pkg::CH_LO_A) begin
            do_byte = 1'b1; byte_val = sed_pkg::BYTE_BEL;
          end else if (cp == sed_pkg::CH_LO_B) begin
            do_byte = 1'b1; byte_val = sed_pkg::BYTE_BS;
          end else if (cp == sed_pkg::CH_LO_E) begin
            do_byte = 1'b1; byte_val = sed_pkg::BYTE_ESC;
          end else if (cp == sed_pkg::CH_LO_N) begin
            do_byte = 1'b1; byte_val = sed_pkg::BYTE_LF;
          end else if (cp == sed_pkg::CH_LO_R) begin
            do_byte = 1'b1; byte_val = sed_pkg::BYTE_CR;
          end else if (cp == sed_pkg::CH_LO_T) begin
            do_byte = 1'b1; byte_val = sed_pkg::BYTE_TAB;
          end else if (cp == sed_pkg::CH_LO_V) begin
            do_byte = 1'b1; byte_val = sed_pkg::BYTE_VT;
          end else if (cp == sed_pkg::CH_BSLASH || cp == sed_pkg::CH_SQUOTE ||
                       cp == sed_pkg::CH_DQUOTE) begin
            do_byte = 1'b1; byte_val = cp[7:0];
          end else if (cp == sed_pkg::CH_LO_X) begin
            mode_nxt = sed_pkg::MODE_DIGITS;
            kind_nxt = sed_pkg::KIND_HEX_BYTE;
            dl_nxt   = 4'd2;
            acc_nxt  = '0;
          end else if (cp == sed_pkg::CH_LO_U) begin
            mode_nxt = sed_pkg::MODE_DIGITS;
            kind_nxt = sed_pkg::KIND_UNICODE;
            dl_nxt   = 4'd4;
            acc_nxt  = '0;
          end else if (cp == sed_pkg::CH_UP_U) begin
            mode_nxt = sed_pkg::MODE_DIGITS;
            kind_nxt = sed_pkg::KIND_UNICODE;
            dl_nxt   = 4'd8;
            acc_nxt  = '0;
          end else begin
            dv = sed_pkg::digit_value(cp, sed_pkg::KIND_OCTAL);
            if (!dv[4]) begin
              do_flag   = 1'b1;
              flag_stat = sed_pkg::ST_BAD_DIGIT;
            end else begin
              mode_nxt = sed_pkg::MODE_DIGITS;
              kind_nxt = sed_pkg::KIND_OCTAL;
              dl_nxt   = 4'd2;
              acc_nxt  = {{(sed_pkg::ACC_W-3){1'b0}}, dv[2:0]};
            end
          end
        end
        sed_pkg::MODE_DIGITS: begin
          if (cp != sed_pkg::CH_UNDER) begin
            dv = sed_pkg::digit_value(cp, kind_r);
            if (!dv[4]) begin
              mode_nxt  = sed_pkg::MODE_PLAIN;
              do_flag   = 1'b1;
              flag_stat = sed_pkg::ST_BAD_DIGIT;
            end else begin
              acc_new = (kind_r == sed_pkg::KIND_OCTAL) ?
                        {acc_r[sed_pkg::ACC_W-4:0], dv[2:0]} :
                        {acc_r[sed_pkg::ACC_W-5:0], dv[3:0]};
              acc_nxt = acc_new;
              dl_dec  = (dl_r != 4'd0) ? dl_r - 4'd1 : 4'd0;
              dl_nxt  = dl_dec;
              if (dl_dec == 4'd0) begin
                mode_nxt = sed_pkg::MODE_PLAIN;
                if (kind_r == sed_pkg::KIND_UNICODE) begin
                  if (acc_new > sed_pkg::CP_MAX ||
                      (acc_new >= sed_pkg::SURR_FIRST && acc_new <= sed_pkg::SURR_LAST)) begin
                    do_flag   = 1'b1;
                    flag_stat = sed_pkg::ST_BAD_CODE_POINT;
                  end else begin
                    do_enc  = 1'b1;
                    enc_src = acc_new[sed_pkg::CP_W-1:0];
                  end
                end else begin
                  do_byte  = 1'b1;
                  byte_val = acc_new[7:0];
                end
              end
            end
          end
        end
        default: begin
          mode_nxt = sed_pkg::MODE_PLAIN;
        end
      endcase
      if (do_flag) err_nxt = 1'b1;
      if (last && !err_nxt && mode_nxt != sed_pkg::MODE_PLAIN) begin
        do_eie  = 1'b1;
        err_nxt = 1'b1;
      end
    end

    if (in_fire && last) begin
      mode_nxt = sed_pkg::MODE_PLAIN;
      kind_nxt = sed_pkg::KIND_HEX_BYTE;
      dl_nxt   = '0;
      acc_nxt  = '0;
      err_nxt  = 1'b0;
    end
  end

  assign enc = sed_pkg::utf8_encode(enc_src);

  // result list for this request
  always_comb begin
    n = '0;
    for (int i = 0; i < sed_pkg::MAX_RES; i++) begin
      list[i] = '0;
    end
    if (do_enc) begin
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < enc.len) begin
          list[n].out_byte = enc.bytes[k];
          list[n].status   = sed_pkg::ST_BYTE;
          n = n + 3'd1;
        end
      end
    end
    if (do_byte) begin
      list[n].out_byte = byte_val;
      list[n].status   = sed_pkg::ST_BYTE;
      n = n + 3'd1;
    end
    if (do_flag) begin
      list[n].status = flag_stat;
      n = n + 3'd1;
    end
    if (do_eie) begin
      list[n].status = sed_pkg::ST_END_IN_ESCAPE;
      n = n + 3'd1;
    end
    if (last) begin
      list[n].status = sed_pkg::ST_COMPLETE;
      n = n + 3'd1;
    end
    for (int i = 0; i < sed_pkg::MAX_RES; i++) begin
      list[i].run_end = ((3'(i) + 3'd1) == n);
    end
  end

  // result shift register
  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      for (int i = 0; i < sed_pkg::MAX_RES - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      cnt_nxt = cnt_r - 3'd1;
    end
    if (in_fire && n != '0) begin
      q_nxt   = list;
      cnt_nxt = n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sed_pkg::MODE_PLAIN;
      kind_r <= sed_pkg::KIND_HEX_BYTE;
      dl_r   <= '0;
      acc_r  <= '0;
      err_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      kind_r <= kind_nxt;
      dl_r   <= dl_nxt;
      acc_r  <= acc_nxt;
      err_r  <= err_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

// File: sv/sed_checker.sv
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks for the string escape decoder, bound to string_escape_decoder_core.
// ----------------------------------------------------------------------------
module sed_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input sed_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input sed_pkg::out_t out_data
);

  logic in_fire;
  assign in_fire = in_valid && !in_stall && in_data.end_of_text;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_complete_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sed_pkg::ST_COMPLETE |-> out_data.run_end)
    else $error("completion result not last of its request");

  a_eie_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sed_pkg::ST_END_IN_ESCAPE |-> !out_data.run_end)
    else $error("end inside escape not followed by completion");

  a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == sed_pkg::ST_END_IN_ESCAPE ||
                  out_data.status == sed_pkg::ST_BAD_DIGIT ||
                  out_data.status == sed_pkg::ST_BAD_CODE_POINT ||
                  out_data.status == sed_pkg::ST_COMPLETE)
    |-> out_data.out_byte == 8'h00)
    else $error("status result carries a byte");

  a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("final request gave no result");

endmodule

bind string_escape_decoder_core sed_checker u_sed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/sv/tb_string_escape_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_string_escape_decoder_core
// Self-checking bench for the string escape decoder. A short table of
// literals hits the encoding extremes, the escape forms and the error paths,
// then random literals (mostly well-formed, some broken or cut short) are
// streamed under random sender gaps and receiver stalls. Every result is
// checked field by field against the table or a decoder model in the bench.
// ----------------------------------------------------------------------------
module tb_string_escape_decoder_core;
  import sed_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int SQUEEZE_LEN = 300;
  localparam int DRAIN_WAIT  = 20;
  localparam int RAND_TARGET = 195;
  localparam int PRINT_CAP   = 40;

  // one literal character plus any result that is known by inspection
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            eot;
    logic [1:0]      n;
    logic [7:0]      b0;
    status_t         s0;
    logic [7:0]      b1;
    status_t         s1;
  } row_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  row_t            text_q[$];
  logic [CP_W-1:0] lit_q[$];
  out_t            fresh_q[$];
  out_t            decoded_q[$];
  int              served = 0;
  int              mismatches = 0;
  int              quiet_cycles = 0;
  bit              tail_mode = 1'b0;
  bit              squeezed = 1'b0;

  // decoder model state
  mode_t       esc_mode = MODE_PLAIN;
  logic [3:0]  esc_left = '0;
  logic [31:0] esc_acc = '0;
  kind_t       esc_kind = KIND_HEX_BYTE;
  logic        err_seen = 1'b0;

  row_t dir_rows [29] = '{
    '{21'h000041, 1'b0, 2'd1, 8'h41, ST_BYTE, 8'h00, ST_BYTE},
    '{21'h000000, 1'b0, 2'd1, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{21'h0007FF, 1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{21'h00FFFF, 1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{21'h1FFFFF, 1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{21'h00D800, 1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_BSLASH,  1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_LO_E,    1'b0, 2'd1, BYTE_ESC, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_BSLASH,  1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_LO_X,    1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{21'h000034, 1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_UNDER,   1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_UP_F,    1'b0, 2'd1, 8'h4F, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_BSLASH,  1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_SEVEN,   1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_SEVEN,   1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_SEVEN,   1'b0, 2'd1, 8'hFF, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_BSLASH,  1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_LO_U,    1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{21'h000044, 1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{21'h000038, 1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_ZERO,    1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_ZERO,    1'b0, 2'd1, 8'h00, ST_BAD_CODE_POINT, 8'h00, ST_BYTE},
    '{21'h00007A, 1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{21'h000071, 1'b1, 2'd1, 8'h00, ST_COMPLETE, 8'h00, ST_BYTE},
    '{CH_BSLASH,  1'b1, 2'd2, 8'h00, ST_END_IN_ESCAPE, 8'h00, ST_COMPLETE},
    '{CH_BSLASH,  1'b0, 2'd0, 8'h00, ST_BYTE, 8'h00, ST_BYTE},
    '{CH_NINE,    1'b0, 2'd1, 8'h00, ST_BAD_DIGIT, 8'h00, ST_BYTE},
    '{21'h000041, 1'b1, 2'd1, 8'h00, ST_COMPLETE, 8'h00, ST_BYTE}
  };

  logic [CP_W-1:0] simple_esc [10] = '{CH_LO_A, CH_LO_B, CH_LO_E, CH_LO_N, CH_LO_R,
                                       CH_LO_T, CH_LO_V, CH_BSLASH, CH_SQUOTE, CH_DQUOTE};
  logic [CP_W-1:0] bad_first [6] = '{21'h38, CH_NINE, CH_UNDER, 21'h71, 21'h47, 21'h2603};
  logic [CP_W-1:0] bad_hex [4] = '{21'h67, 21'h47, 21'h20, 21'h10FFFF};
  logic [CP_W-1:0] bad_oct [3] = '{21'h38, CH_NINE, CH_LO_A};

  string_escape_decoder_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("error: %s got %0h want %0h", what, got, want);
    end
  endtask

  // ---------------- decoder model ----------------

  function automatic void emit(logic [7:0] b, status_t s);
    fresh_q.push_back('{out_byte: b, status: s, run_end: 1'b0});
  endfunction

  function automatic void raise_error(status_t s);
    emit(8'h00, s);
    err_seen = 1'b1;
  endfunction

  function automatic void open_escape(kind_t k, logic [3:0] n, logic [31:0] a);
    esc_mode = MODE_DIGITS;
    esc_kind = k;
    esc_left = n;
    esc_acc  = a;
  endfunction

  function automatic void emit_utf8(logic [31:0] v);
    if (v < 32'h80) begin
      emit(v[7:0], ST_BYTE);
    end else if (v < 32'h800) begin
      emit(8'hC0 | 8'(v >> 6), ST_BYTE);
      emit(8'h80 | 8'(v & 32'h3F), ST_BYTE);
    end else if (v < 32'h10000) begin
      emit(8'hE0 | 8'(v >> 12), ST_BYTE);
      emit(8'h80 | 8'((v >> 6) & 32'h3F), ST_BYTE);
      emit(8'h80 | 8'(v & 32'h3F), ST_BYTE);
    end else begin
      emit(8'hF0 | 8'((v >> 18) & 32'h7), ST_BYTE);
      emit(8'h80 | 8'((v >> 12) & 32'h3F), ST_BYTE);
      emit(8'h80 | 8'((v >> 6) & 32'h3F), ST_BYTE);
      emit(8'h80 | 8'(v & 32'h3F), ST_BYTE);
    end
  endfunction

  // {is digit, value} in the radix of the escape kind
  function automatic logic [4:0] radix_digit(logic [CP_W-1:0] cp, kind_t k);
    if (k == KIND_OCTAL) begin
      return (cp inside {[CH_ZERO:CH_SEVEN]}) ? {1'b1, 4'(cp - CH_ZERO)} : 5'd0;
    end
    if (cp inside {[CH_ZERO:CH_NINE]}) return {1'b1, 4'(cp - CH_ZERO)};
    if (cp inside {[CH_LO_A:CH_LO_F]}) return {1'b1, 4'(cp - CH_LO_A + 10)};
    if (cp inside {[CH_UP_A:CH_UP_F]}) return {1'b1, 4'(cp - CH_UP_A + 10)};
    return 5'd0;
  endfunction

  function automatic void decode_code_point(in_t req);
    logic [CP_W-1:0] cp;
    logic [4:0]      dv;
    cp = req.code_point;
    fresh_q.delete();
    if (!err_seen) begin
      case (esc_mode)
        MODE_PLAIN: begin
          if (cp == CH_BSLASH) esc_mode = MODE_AFTER_BSLASH;
          else emit_utf8({11'd0, cp});
        end
        MODE_AFTER_BSLASH: begin
          esc_mode = MODE_PLAIN;
          case (cp)
            CH_LO_A: emit(BYTE_BEL, ST_BYTE);
            CH_LO_B: emit(BYTE_BS, ST_BYTE);
            CH_LO_E: emit(BYTE_ESC, ST_BYTE);
            CH_LO_N: emit(BYTE_LF, ST_BYTE);
            CH_LO_R: emit(BYTE_CR, ST_BYTE);
            CH_LO_T: emit(BYTE_TAB, ST_BYTE);
            CH_LO_V: emit(BYTE_VT, ST_BYTE);
            CH_BSLASH, CH_SQUOTE, CH_DQUOTE: emit(cp[7:0], ST_BYTE);
            CH_LO_X: open_escape(KIND_HEX_BYTE, 4'd2, '0);
            CH_LO_U: open_escape(KIND_UNICODE, 4'd4, '0);
            CH_UP_U: open_escape(KIND_UNICODE, 4'd8, '0);
            default: begin
              dv = radix_digit(cp, KIND_OCTAL);
              if (dv[4]) open_escape(KIND_OCTAL, 4'd2, {28'd0, dv[3:0]});
              else raise_error(ST_BAD_DIGIT);
            end
          endcase
        end
        MODE_DIGITS: begin
          if (cp != CH_UNDER) begin
            dv = radix_digit(cp, esc_kind);
            if (!dv[4]) begin
              esc_mode = MODE_PLAIN;
              raise_error(ST_BAD_DIGIT);
            end else begin
              if (esc_kind == KIND_OCTAL) esc_acc = {esc_acc[28:0], dv[2:0]};
              else esc_acc = {esc_acc[27:0], dv[3:0]};
              if (esc_left != 0) esc_left = esc_left - 4'd1;
              if (esc_left == 0) begin
                esc_mode = MODE_PLAIN;
                if (esc_kind != KIND_UNICODE) begin
                  emit(esc_acc[7:0], ST_BYTE);
                end else if (esc_acc > CP_MAX ||
                             (esc_acc >= SURR_FIRST && esc_acc <= SURR_LAST)) begin
                  raise_error(ST_BAD_CODE_POINT);
                end else begin
                  emit_utf8(esc_acc);
                end
              end
            end
          end
        end
        default: esc_mode = MODE_PLAIN;
      endcase
      if (req.end_of_text && !err_seen && esc_mode != MODE_PLAIN) begin
        raise_error(ST_END_IN_ESCAPE);
      end
    end
    if (req.end_of_text) begin
      emit(8'h00, ST_COMPLETE);
      esc_mode = MODE_PLAIN;
      esc_left = '0;
      esc_acc  = '0;
      esc_kind = KIND_HEX_BYTE;
      err_seen = 1'b0;
    end
    if (fresh_q.size() != 0) fresh_q[$].run_end = 1'b1;
  endfunction

  // ---------------- random literals ----------------

  function automatic logic [CP_W-1:0] digit_char(logic [3:0] nib);
    if (nib < 10) return CH_ZERO + CP_W'(nib);
    return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + CP_W'(nib - 4'd10);
  endfunction

  function automatic void push_digits(logic [31:0] v, int n, bit octal);
    logic [3:0] nib;
    for (int i = n - 1; i >= 0; i--) begin
      nib = octal ? (4'(v >> (3 * i)) & 4'h7) : 4'(v >> (4 * i));
      if (i != n - 1 && $urandom_range(0, 5) == 0) lit_q.push_back(CH_UNDER);
      lit_q.push_back(digit_char(nib));
    end
  endfunction

  function automatic logic [CP_W-1:0] plain_cp();
    logic [CP_W-1:0] c;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: begin
        c = CP_W'($urandom_range(0, 'h7F));
        if (c == CH_BSLASH) c = CH_UP_A;
      end
      4: c = CP_W'($urandom_range('h80, 'h7FF));
      5: c = CP_W'($urandom_range('h800, 'hFFFF));
      6: c = CP_W'($urandom_range('h10000, 'h10FFFF));
      default: c = CP_W'($urandom_range('h110000, 'h1FFFFF));
    endcase
    return c;
  endfunction

  function automatic logic [31:0] pick_scalar(bit wide);
    logic [31:0] v;
    int          r;
    r = $urandom_range(0, 9);
    if (r < 2) v = 32'hD800 + $urandom_range(0, 'h7FF);
    else if (wide && r == 2) v = $urandom_range(32'h110000, 32'h1FFFFF);
    else if (wide && r == 3) v = $urandom() | 32'h0020_0000;
    else begin
      v = wide ? $urandom_range(0, 32'h10FFFF) : $urandom_range(0, 32'hFFFF);
      if (v >= SURR_FIRST && v <= SURR_LAST) v = v ^ 32'h8000;
    end
    return v;
  endfunction

  // returns the number of items up to and including the first error
  function automatic int gen_literal();
    int          nseg, pick, live;
    bit          dead, cut, err_now;
    logic [31:0] v;
    lit_q.delete();
    live = 0;
    dead = 1'b0;
    cut  = 1'b0;
    nseg = $urandom_range(1, 8);
    for (int s = 0; s < nseg && !cut; s++) begin
      pick = $urandom_range(0, 99);
      err_now = 1'b0;
      if (pick < 30) begin
        lit_q.push_back(plain_cp());
      end else if (pick < 50) begin
        lit_q.push_back(CH_BSLASH);
        lit_q.push_back(simple_esc[$urandom_range(0, 9)]);
      end else if (pick < 60) begin
        lit_q.push_back(CH_BSLASH);
        lit_q.push_back(CH_LO_X);
        push_digits($urandom_range(0, 255), 2, 1'b0);
      end else if (pick < 78) begin
        v = pick_scalar(pick >= 70);
        lit_q.push_back(CH_BSLASH);
        lit_q.push_back(pick >= 70 ? CH_UP_U : CH_LO_U);
        push_digits(v, pick >= 70 ? 8 : 4, 1'b0);
        err_now = (v > CP_MAX) || (v >= SURR_FIRST && v <= SURR_LAST);
      end else if (pick < 88) begin
        lit_q.push_back(CH_BSLASH);
        push_digits($urandom_range(0, 511), 3, 1'b1);
      end else if (pick < 94) begin
        lit_q.push_back(CH_BSLASH);
        case ($urandom_range(0, 2))
          0: lit_q.push_back(bad_first[$urandom_range(0, 5)]);
          1: begin
            lit_q.push_back(CH_LO_X);
            push_digits($urandom_range(0, 15), 1, 1'b0);
            lit_q.push_back(bad_hex[$urandom_range(0, 3)]);
          end
          default: begin
            push_digits($urandom_range(0, 63), 2, 1'b1);
            lit_q.push_back(bad_oct[$urandom_range(0, 2)]);
          end
        endcase
        err_now = 1'b1;
      end else begin
        // literal ends in the middle of an escape
        lit_q.push_back(CH_BSLASH);
        case ($urandom_range(0, 3))
          0: ;
          1: begin
            lit_q.push_back(CH_LO_X);
            push_digits($urandom_range(0, 15), $urandom_range(0, 1), 1'b0);
          end
          2: begin
            lit_q.push_back(CH_UP_U);
            push_digits($urandom(), $urandom_range(0, 7), 1'b0);
          end
          default: push_digits($urandom_range(0, 63), $urandom_range(1, 2), 1'b1);
        endcase
        cut = 1'b1;
      end
      if (!dead) live = lit_q.size();
      dead = dead | err_now;
      if (dead && $urandom_range(0, 1)) cut = 1'b1;
    end
    foreach (lit_q[i]) begin
      text_q.push_back('{lit_q[i], (i == lit_q.size() - 1), 2'd0, 8'h00, ST_BYTE,
                         8'h00, ST_BYTE});
    end
    return live;
  endfunction

  // ---------------- sender ----------------

  initial begin : sender
    int live_total, gap_pct, tail_start;
    foreach (dir_rows[i]) text_q.push_back(dir_rows[i]);
    live_total = 0;
    while (live_total < RAND_TARGET) live_total += gen_literal();
    tail_start = (text_q.size() * 85) / 100;
    gap_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < text_q.size(); i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 35;
        endcase
      end
      if (i >= tail_start) begin
        tail_mode = 1'b1;
        gap_pct = 0;
      end
      if ($urandom_range(0, 99) < gap_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= '{code_point: text_q[i].cp, end_of_text: text_q[i].eot};
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (decoded_q.size() != 0) report_mismatch("results never arrived", 0, decoded_q.size());
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------- receiver ----------------

  initial begin : receiver
    int   span;
    logic hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (tail_mode) begin
        hold = 1'b0;
        span = 1;
      end else if (!squeezed && served >= 60) begin
        // long hold so the output fills and the input backs up
        hold = 1'b1;
        span = SQUEEZE_LEN;
        squeezed = 1'b1;
      end else begin
        hold = ($urandom_range(0, 3) == 0);
        span = hold ? $urandom_range(1, 19) : $urandom_range(1, 40);
      end
      out_stall <= hold;
      repeat (span) @(posedge clk);
    end
  end

  // ---------------- prediction and checking ----------------

  always @(posedge clk) begin : scoreboard
    row_t r;
    out_t want;
    if (rst_n && in_valid && !in_stall) begin
      r = text_q[served];
      served++;
      decode_code_point(in_data);
      if (r.n == 2'd0) begin
        foreach (fresh_q[k]) decoded_q.push_back(fresh_q[k]);
      end else begin
        decoded_q.push_back('{out_byte: r.b0, status: r.s0, run_end: (r.n == 2'd1)});
        if (r.n == 2'd2) decoded_q.push_back('{out_byte: r.b1, status: r.s1, run_end: 1'b1});
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected result", int'(out_data), 0);
      end else begin
        want = decoded_q.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          report_mismatch("out_byte", int'(out_data.out_byte), int'(want.out_byte));
        end
        if (out_data.status !== want.status) begin
          report_mismatch("status", int'(out_data.status), int'(want.status));
        end
        if (out_data.run_end !== want.run_end) begin
          report_mismatch("run_end", int'(out_data.run_end), int'(want.run_end));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
